@@ sv/tms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants of the tick momentum signal block
// Widths, register indexes and the records that travel between the modules.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int VENUES        = 16;
    localparam int HISTORY_DEPTH = 64;

    localparam int VENUE_W  = 4;
    localparam int PRICE_W  = 32;
    localparam int THR_W    = 7;
    localparam int QTY_W    = 24;
    localparam int NUM_W    = 32;
    localparam int VENUE_AW = (VENUES > 1) ? $clog2(VENUES) : 1;
    localparam int RUN_W    = $clog2(HISTORY_DEPTH);
    localparam int CMP_W    = (THR_W > RUN_W) ? THR_W + 1 : RUN_W + 1;

    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(HISTORY_DEPTH - 1);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RUN_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_SIZE    = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET  = THR_W'(3);
    localparam logic [QTY_W-1:0] ORDER_SIZE_RESET = QTY_W'(100);

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Per-venue history entry held in the state memory.
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [RUN_W-1:0]   rise;
        logic [RUN_W-1:0]   fall;
    } entry_t;

    // One emitted order.
    typedef struct packed {
        logic               side;
        logic [NUM_W-1:0]   number;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
        logic [VENUE_W-1:0] venue;
    } order_t;

    // Decision of the update stage.
    typedef struct packed {
        logic emit;
        logic side;
    } decision_t;

endpackage

@@ sv/tms_state_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_state_ram: per-venue history memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tms_state_ram (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [tms_pkg::VENUE_AW-1:0] wr_addr,
    input  tms_pkg::entry_t          wr_data,
    input  logic [tms_pkg::VENUE_AW-1:0] rd_addr,
    output tms_pkg::entry_t          rd_data
);
    import tms_pkg::*;

    entry_t mem [VENUES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/tms_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_update: per-tick run update and order decision
// Compares the tick against the venue's last price, steps the run counts and
// decides whether a buy or sell order goes out.
// ----------------------------------------------------------------------------
module tms_update (
    input  logic [tms_pkg::PRICE_W-1:0] price,
    input  logic                        seen,
    input  tms_pkg::entry_t             cur,
    input  logic [tms_pkg::THR_W-1:0]   run_threshold,
    output tms_pkg::entry_t             upd,
    output tms_pkg::decision_t          dec
);
    import tms_pkg::*;

    logic [THR_W-1:0] need;
    logic [RUN_W-1:0] rise_bump;
    logic [RUN_W-1:0] fall_bump;

    assign rise_bump = (cur.rise == RUN_MAX) ? cur.rise : cur.rise + RUN_W'(1);
    assign fall_bump = (cur.fall == RUN_MAX) ? cur.fall : cur.fall + RUN_W'(1);

    always_comb begin
        upd.price = price;
        priority if (!seen) begin
            upd.rise = '0;
            upd.fall = '0;
        end else if (price > cur.price) begin
            upd.rise = rise_bump;
            upd.fall = '0;
        end else if (price < cur.price) begin
            upd.rise = '0;
            upd.fall = fall_bump;
        end else begin
            upd.rise = '0;
            upd.fall = '0;
        end
    end

    // A threshold of zero acts as a threshold of one.
    assign need = (run_threshold == '0) ? '0 : run_threshold - THR_W'(1);

    always_comb begin
        dec.emit = 1'b1;
        dec.side = SIDE_BUY;
        priority if (CMP_W'(upd.rise) >= CMP_W'(need)) begin
            dec.side = SIDE_BUY;
        end else if (CMP_W'(upd.fall) >= CMP_W'(need)) begin
            dec.side = SIDE_SELL;
        end else begin
            dec.emit = 1'b0;
        end
    end

endmodule

@@ sv/tms_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_out_fifo: small order queue in front of the result channel
// Decouples the update stage from back-pressure on the master side.
// ----------------------------------------------------------------------------
module tms_out_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  tms_pkg::order_t             push_data,
    output logic [tms_pkg::FIFO_CW-1:0] count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tms_pkg::order_t             out_data
);
    import tms_pkg::*;

    order_t             fifo_q [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_q[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_q[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/tick_momentum_signal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_momentum_signal: per-venue tick momentum detector
// Turns a stream of market ticks into buy and sell orders on price runs.
// ----------------------------------------------------------------------------
// Each accepted tick word carries a venue and a price. For every venue the
// block remembers the last price and how many consecutive strictly rising and
// strictly falling steps end at the latest tick; both counts saturate at the
// history depth less one. When the latest run_threshold prices of a venue all
// rise, the tick produces a buy order; failing that, when they all fall, a
// sell order. A threshold of one (or zero) makes every tick a buy, and a
// threshold above the history depth never fires. Orders carry a 32-bit
// wrapping sequence number starting at 1, the venue, the tick price and the
// configured order size. The block takes one tick every clock cycle
// indefinitely while results drain: the venue history sits in a memory with a
// registered read, the tick's entry is read as the word is accepted, updated
// in the following cycle and written back, and a forwarding register covers
// a tick that hits the venue written in the same cycle. The order word passes
// through the update stage registers and the order buffer before it shows on
// the master side. Orders queue in a four-word buffer; the slave side stalls
// when the queued orders plus a tick in the update stage would fill it. After
// reset no venue has been seen, and configuration writes should be made while
// no ticks are in flight.
// ----------------------------------------------------------------------------
module tick_momentum_signal (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [tms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tms_pkg::CFG_DAT_W-1:0] cfg_data,
    // Tick input. s_tdata, low bit up: venue_index[3:0], tick_price[35:4], zero fill.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tms_pkg::S_TDATA_W-1:0] s_tdata,
    // Order output. m_tdata, low bit up: order_venue[3:0], order_price[35:4],
    // order_quantity[59:36], order_number[91:60], zero fill.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tms_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: order_side (0 buy, 1 sell).
    output logic                          m_tuser
);
    import tms_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0] run_threshold_reg;
    logic [QTY_W-1:0] order_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_threshold_reg <= THRESHOLD_RESET;
            order_size_reg    <= ORDER_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RUN_THRESHOLD: run_threshold_reg <= cfg_data[THR_W-1:0];
                REG_ORDER_SIZE:    order_size_reg    <= cfg_data[QTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Input unpacking and acceptance.
    logic [VENUE_W-1:0] s_venue;
    logic [PRICE_W-1:0] s_price;
    logic               s_accept;
    logic               venue_ok;
    logic [FIFO_CW-1:0] fifo_count;

    assign s_venue  = s_tdata[VENUE_W-1:0];
    assign s_price  = s_tdata[VENUE_W +: PRICE_W];
    assign venue_ok = (32'(s_venue) < VENUES);
    assign s_accept = s_tvalid && s_tready;

    // The buffer must have room for the tick in the update stage and the new
    // one; the condition depends on registers only.
    logic               s1_valid_reg;
    assign s_tready = ((fifo_count + FIFO_CW'(s1_valid_reg)) < FIFO_CW'(FIFO_DEPTH));

    // Update stage registers. Ticks for venues outside the table are dropped
    // here and leave no trace.
    logic [VENUE_AW-1:0] s1_addr_reg;
    logic [VENUE_W-1:0]  s1_venue_reg;
    logic [PRICE_W-1:0]  s1_price_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept && venue_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg  <= s_venue[VENUE_AW-1:0];
            s1_venue_reg <= s_venue;
            s1_price_reg <= s_price;
        end
    end

    // History memory: read as the tick is accepted, written from the update
    // stage.
    entry_t ram_rd_data;
    entry_t upd_entry;

    tms_state_ram u_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (upd_entry),
        .rd_addr (s_venue[VENUE_AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // The read sees every write before its own edge; the write made at that
    // same edge is held here and forwarded when the venue matches.
    logic                fwd_valid_reg;
    logic [VENUE_AW-1:0] fwd_addr_reg;
    entry_t              fwd_entry_reg;
    entry_t              cur_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            fwd_addr_reg  <= s1_addr_reg;
            fwd_entry_reg <= upd_entry;
        end
    end

    assign cur_entry = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ?
                       fwd_entry_reg : ram_rd_data;

    // Seen flags live in flip-flops so that reset clears them at once; an
    // unseen venue ignores whatever the memory returns.
    logic [VENUES-1:0] seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (s1_valid_reg) begin
            seen_reg[s1_addr_reg] <= 1'b1;
        end
    end

    decision_t dec;

    tms_update u_update (
        .price         (s1_price_reg),
        .seen          (seen_reg[s1_addr_reg]),
        .cur           (cur_entry),
        .run_threshold (run_threshold_reg),
        .upd           (upd_entry),
        .dec           (dec)
    );

    // Order numbering: the counter holds the last number issued.
    logic [NUM_W-1:0] order_count_reg;
    logic [NUM_W-1:0] order_count_next;
    logic             emit;
    order_t           new_order;

    assign emit             = s1_valid_reg && dec.emit;
    assign order_count_next = order_count_reg + NUM_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_count_reg <= '0;
        end else if (emit) begin
            order_count_reg <= order_count_next;
        end
    end

    always_comb begin
        new_order.side     = dec.side;
        new_order.number   = order_count_next;
        new_order.quantity = order_size_reg;
        new_order.price    = s1_price_reg;
        new_order.venue    = s1_venue_reg;
    end

    // Result queue and output packing.
    order_t out_order;

    tms_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (new_order),
        .count     (fifo_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_order)
    );

    assign m_tdata = {4'b0000, out_order.number, out_order.quantity,
                      out_order.price, out_order.venue};
    assign m_tuser = out_order.side;

endmodule

@@ sv/tms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_checker: port-level checks for the tick momentum signal block
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module tms_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tms_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import tms_pkg::*;

    logic [NUM_W-1:0] last_num_reg;
    logic [NUM_W-1:0] m_num;

    assign m_num = m_tdata[60 +: NUM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_num_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_num_reg <= m_num;
        end
    end

    // A stalled order word stays offered.
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("order word withdrawn while stalled");

    // A stalled order word keeps its contents.
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("order word changed while stalled");

    // Orders leave in sequence, starting at one after reset.
    a_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> m_num == last_num_reg + NUM_W'(1))
        else $error("order number out of sequence");

    // With no order waiting, the buffer has room and ticks are taken.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("tick input stalled with no order pending");

endmodule

bind tick_momentum_signal tms_checker u_tms_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the tick momentum signal block
// Drives market tick words into the block and checks every order word against
// a behavioral predictor kept beside the instance.
// ----------------------------------------------------------------------------
// Each accepted tick word updates the predictor's copy of the per-venue
// history and, when a rising or falling run is long enough, queues the order
// that the block must emit. A monitor compares each accepted order word field
// by field with the oldest queued order. The stimulus runs a few named tests in
// turn: short directed runs under the reset settings, the threshold of one and
// zero, saturated runs at the largest and out-of-range thresholds, and then
// several phases of random trending ticks with random idling on both sides.
// Settings change only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
    import tms_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;

    // Bit positions of the order fields inside m_tdata.
    localparam int PRICE_LSB  = VENUE_W;
    localparam int QTY_LSB    = VENUE_W + PRICE_W;
    localparam int NUMBER_LSB = VENUE_W + PRICE_W + QTY_W;

    typedef struct {
        logic               side;
        logic [VENUE_W-1:0] venue;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
        logic [NUM_W-1:0]   number;
    } order_rec_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Predictor copy of the settings and the per-venue history.
    logic [THR_W-1:0]   thr_setting  = THRESHOLD_RESET;
    logic [QTY_W-1:0]   size_setting = ORDER_SIZE_RESET;
    logic               venue_seen [VENUES];
    logic [PRICE_W-1:0] venue_last [VENUES];
    logic [RUN_W-1:0]   rise_len   [VENUES];
    logic [RUN_W-1:0]   fall_len   [VENUES];
    logic [NUM_W-1:0]   orders_issued = '0;
    order_rec_t         pending_orders [$];

    // Random feed state: a drifting price and a trend direction per venue.
    logic [PRICE_W-1:0] feed_price [VENUES];
    logic               feed_down  [VENUES];
    logic [VENUE_W-1:0] feed_venue = '0;

    int unsigned tx_gap_max   = 0;
    int unsigned rx_stall_max = 0;
    int unsigned rx_hold_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    tick_momentum_signal dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Applies one tick to the predictor. Returns 1 and fills the order when
    // the tick completes a long enough run.
    function automatic bit predict_order(input logic [VENUE_W-1:0] venue,
                                         input logic [PRICE_W-1:0] price,
                                         output order_rec_t ord);
        logic [THR_W-1:0] need;
        if (!venue_seen[venue]) begin
            // First tick of a venue starts both runs at zero.
            rise_len[venue]   = '0;
            fall_len[venue]   = '0;
            venue_seen[venue] = 1'b1;
        end else if (price > venue_last[venue]) begin
            rise_len[venue] = (rise_len[venue] == RUN_MAX) ? RUN_MAX : rise_len[venue] + 1'b1;
            fall_len[venue] = '0;
        end else if (price < venue_last[venue]) begin
            fall_len[venue] = (fall_len[venue] == RUN_MAX) ? RUN_MAX : fall_len[venue] + 1'b1;
            rise_len[venue] = '0;
        end else begin
            rise_len[venue] = '0;
            fall_len[venue] = '0;
        end
        venue_last[venue] = price;

        // A threshold of zero acts as one; the buy side is tested first.
        need = (thr_setting == '0) ? '0 : thr_setting - 1'b1;
        if (THR_W'(rise_len[venue]) >= need) begin
            ord.side = SIDE_BUY;
        end else if (THR_W'(fall_len[venue]) >= need) begin
            ord.side = SIDE_SELL;
        end else begin
            return 1'b0;
        end
        orders_issued = orders_issued + 1'b1;
        ord.venue    = venue;
        ord.price    = price;
        ord.quantity = size_setting;
        ord.number   = orders_issued;
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input logic [NUM_W-1:0] want,
                                          input logic [NUM_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Next price of the random feed for one venue. Most ticks follow the
    // venue's trend, which flips now and then; a few repeat the price or jump
    // to a random value.
    function automatic logic [PRICE_W-1:0] drift_price(input logic [VENUE_W-1:0] venue);
        logic [PRICE_W:0] sum;
        int unsigned      pick;
        int unsigned      delta;
        pick  = $urandom_range(0, 99);
        delta = $urandom_range(1, 500);
        if (pick < 15)
            feed_down[venue] = ~feed_down[venue];
        if (pick >= 15 && pick < 23) begin
            // Repeat the last price.
        end else if (pick >= 23 && pick < 28) begin
            feed_price[venue] = $urandom;
        end else if (!feed_down[venue]) begin
            sum = feed_price[venue] + delta;
            feed_price[venue] = sum[PRICE_W] ? PRICE_W'($urandom) : sum[PRICE_W-1:0];
        end else begin
            feed_price[venue] = (feed_price[venue] < delta) ? PRICE_W'($urandom)
                                                            : feed_price[venue] - delta;
        end
        return feed_price[venue];
    endfunction

    // Writes one register and mirrors it in the predictor's settings.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RUN_THRESHOLD)
            thr_setting = data[THR_W-1:0];
        else if (idx == REG_ORDER_SIZE)
            size_setting = data[QTY_W-1:0];
    endtask

    // The bits above the threshold field carry random junk that the block
    // must drop.
    task automatic write_threshold(input logic [THR_W-1:0] thr);
        logic [CFG_DAT_W-1:0] data;
        data = CFG_DAT_W'($urandom);
        data[THR_W-1:0] = thr;
        write_reg(REG_RUN_THRESHOLD, data);
    endtask

    // Sends one tick word after a random gap. Valid stays high after the
    // handshake so that back-to-back words need no second assignment in the
    // same step; the next gap or idle wait lowers it.
    task automatic send_tick(input logic [VENUE_W-1:0] venue, input logic [PRICE_W-1:0] price);
        int unsigned gap;
        order_rec_t  ord;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'({price, venue});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (predict_order(venue, price, ord))
            pending_orders = {pending_orders, ord};
    endtask

    // Stops sending and waits until every queued order has come out, then
    // lets the pipeline settle since a tick without an order leaves no trace.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_orders.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Short runs under the reset settings: threshold 3, size 100. Covers the
    // first tick of a venue, equal prices, buy and sell, and the price and
    // venue extremes.
    task automatic test_basic_runs();
        tx_gap_max   = 2;
        rx_stall_max = 3;
        send_tick(4'd0, 32'h0000_0000);
        send_tick(4'd15, 32'hFFFF_FFFF);
        send_tick(4'd0, 32'h0000_0001);
        send_tick(4'd0, 32'h0000_0002);
        send_tick(4'd0, 32'h0000_0002);
        send_tick(4'd0, 32'h0000_0001);
        send_tick(4'd0, 32'h0000_0000);
        send_tick(4'd15, 32'hFFFF_FFFE);
        send_tick(4'd15, 32'h8000_0000);
        send_tick(4'd15, 32'h0000_0000);
        send_tick(4'd15, 32'hFFFF_FFFF);
        send_tick(4'd15, 32'hFFFF_FFFF);
        send_tick(4'd5, 32'h5555_5555);
        send_tick(4'd10, 32'hAAAA_AAAA);
        send_tick(4'd5, 32'hAAAA_AAAA);
        send_tick(4'd10, 32'h5555_5555);
        send_tick(4'd5, 32'hFFFF_FFFF);
        send_tick(4'd10, 32'h0000_0000);
        send_tick(4'd5, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    // Threshold one makes every tick a buy, even the first of a venue and a
    // falling or flat one. Zero behaves the same. Threshold two skips the
    // first tick.
    task automatic test_threshold_one_and_zero();
        tx_gap_max   = 0;
        rx_stall_max = 5;
        write_threshold(7'd1);
        write_reg(REG_ORDER_SIZE, 24'hFF_FFFF);
        send_tick(4'd3, 32'd1000);
        send_tick(4'd3, 32'd999);
        send_tick(4'd3, 32'd999);
        send_tick(4'd3, 32'd1001);
        wait_idle();
        write_reg(REG_RUN_THRESHOLD, 24'hFF_FF80);
        send_tick(4'd4, 32'h0001_0000);
        send_tick(4'd4, 32'h0000_FFFF);
        send_tick(4'd4, 32'h0000_FFFF);
        wait_idle();
        write_threshold(7'd2);
        write_reg(REG_ORDER_SIZE, 24'h00_0001);
        send_tick(4'd6, 32'd7);
        send_tick(4'd6, 32'd8);
        send_tick(4'd6, 32'd6);
        wait_idle();
    endtask

    // Long runs: at threshold 64 only the saturated counts fire, and they
    // keep firing once saturated. Thresholds above the history depth never
    // fire.
    task automatic test_saturated_runs();
        tx_gap_max   = 5;
        rx_stall_max = 5;
        write_threshold(7'd64);
        write_reg(REG_ORDER_SIZE, 24'h00_0000);
        for (int i = 0; i < 70; i++)
            send_tick(4'd7, PRICE_W'(1000 + 3 * i));
        for (int i = 1; i <= 70; i++)
            send_tick(4'd7, PRICE_W'(1207 - 3 * i));
        wait_idle();
        write_threshold(7'd65);
        for (int i = 0; i < 70; i++)
            send_tick(4'd8, PRICE_W'(i));
        wait_idle();
        write_threshold(7'd127);
        for (int i = 0; i < 70; i++)
            send_tick(4'd9, 32'hFFFF_FF00 - PRICE_W'(i));
        wait_idle();
    endtask

    // Random trending ticks in phases with different thresholds, order sizes,
    // venue spreads and idling. At least half the ticks stay on the previous venue so
    // that back-to-back hits on one venue are common.
    task automatic test_random_ticks();
        int unsigned thr_plan  [6] = '{2, 3, 4, 6, 2, 3};
        int unsigned span_plan [6] = '{4, 16, 16, 4, 16, 2};
        int unsigned span;
        for (int v = 0; v < VENUES; v++) begin
            feed_price[v] = $urandom;
            feed_down[v]  = $urandom_range(0, 1);
        end
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_threshold(THR_W'(thr_plan[p]));
            write_reg(REG_ORDER_SIZE, QTY_W'($urandom));
            tx_gap_max   = (p % 3 == 0) ? 0 : 5;
            rx_stall_max = (p % 2 == 0 || p == 3) ? 5 : 0;
            if (p == 3) rx_stall_max = 0;
            span = span_plan[p];
            for (int i = 0; i < 224; i++) begin
                if ($urandom_range(0, 1) == 0 || feed_venue >= span)
                    feed_venue = VENUE_W'($urandom_range(0, span - 1));
                send_tick(feed_venue, drift_price(feed_venue));
            end
        end
        wait_idle();
    endtask

    // Result side back-pressure: after each accepted order word, ready drops
    // for a random number of cycles.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            rx_hold_left = $urandom_range(0, rx_stall_max);
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Order monitor: every accepted word must match the oldest queued order.
    always @(posedge aclk) begin
        order_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_orders.size() == 0) begin
                note_mismatch("unexpected order number", '0, m_tdata[NUMBER_LSB +: NUM_W]);
            end else begin
                want = pending_orders[0];
                pending_orders.delete(0);
                if (m_tuser !== want.side)
                    note_mismatch("side", want.side, m_tuser);
                if (m_tdata[VENUE_W-1:0] !== want.venue)
                    note_mismatch("venue", want.venue, m_tdata[VENUE_W-1:0]);
                if (m_tdata[PRICE_LSB +: PRICE_W] !== want.price)
                    note_mismatch("price", want.price, m_tdata[PRICE_LSB +: PRICE_W]);
                if (m_tdata[QTY_LSB +: QTY_W] !== want.quantity)
                    note_mismatch("quantity", want.quantity, m_tdata[QTY_LSB +: QTY_W]);
                if (m_tdata[NUMBER_LSB +: NUM_W] !== want.number)
                    note_mismatch("number", want.number, m_tdata[NUMBER_LSB +: NUM_W]);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL tick_momentum_signal");
        $finish;
    end

    initial begin
        for (int v = 0; v < VENUES; v++) begin
            venue_seen[v] = 1'b0;
            venue_last[v] = '0;
            rise_len[v]   = '0;
            fall_len[v]   = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_runs();
        test_threshold_one_and_zero();
        test_saturated_runs();
        test_random_ticks();

        wait_idle();
        if (pending_orders.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("PASS tick_momentum_signal");
        else
            $display("FAIL tick_momentum_signal");
        $finish;
    end

endmodule
